/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the IMU bias calibration RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/ibcs_pkg.sv */
// ---------------------------------------------------------------------------
// ibcs_pkg
// Shared widths, constants and types of the IMU bias calibration block.
// ---------------------------------------------------------------------------
package ibcs_pkg;

    localparam int NUM_AXES  = 3;
    localparam int RAW_W     = 16;
    localparam int RADS_W    = 22;
    localparam int SUM_W     = 26;
    localparam int MAG_W     = SUM_W - 1;
    localparam int COUNT_W   = 10;
    localparam int FRAC_W    = 16;
    localparam int SCALE_W   = 23;
    localparam int PROD_W    = RAW_W + SCALE_W;

    // Saturation limits of a raw 16-bit reading
    localparam int RAW_MAX   = (2 ** (RAW_W - 1)) - 1;
    localparam int RAW_MIN   = -(2 ** (RAW_W - 1));

    // round(2^32 / (32.8 * 57.3)): LSB to rad/s with 16 fractional bits
    localparam logic signed [SCALE_W-1:0] GYRO_SCALE = 23'sd2285238;

    // Bias divider: magnitude load, one reciprocal multiply, then the bias write-back
    localparam int DIV_STEPS = 1;
    localparam int DIV_LAST  = DIV_STEPS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_LAST + 1);

    // Input action codes
    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_CAL,
        ST_DIV,
        ST_RUN
    } cal_state_t;

    // Per-cycle commands from the calibration controller to every gyro lane
    typedef struct packed {
        logic clear;     // restart: drop sums and bias
        logic accum;     // add this sample into the sum
        logic div_load;  // load sum magnitude into the divider
        logic div_step;  // reciprocal multiply of the magnitude
        logic div_done;  // write the quotient into the bias
        logic s1_load;   // capture corrected sample into stage 1
        logic s1_zero;   // stage 1 gyro value forced to zero
    } lane_ctrl_t;

endpackage

/* rtl/ibcs_cal_ctrl.sv */
// ---------------------------------------------------------------------------
// ibcs_cal_ctrl
// Calibration sequencer: counts calibration samples, runs the bias divider
// and issues per-cycle commands to the gyro lanes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ibcs_cal_ctrl
    import ibcs_pkg::*;
#(
    parameter int CAL_SAMPLES = 300
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       action,
    input  logic       s1_ready,
    output logic       in_ready,
    output logic       calibrated,
    output lane_ctrl_t lane_ctrl
);

    localparam logic [COUNT_W-1:0] CAL_COUNT = COUNT_W'(CAL_SAMPLES);

    cal_state_t             state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   accept;
    logic                   restart;
    logic [COUNT_W-1:0]     count_inc;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CAL;
            count_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign in_ready   = s1_ready && (state_reg != ST_DIV);
    assign accept     = in_valid && in_ready;
    assign restart    = accept && (action == ACT_RESTART);
    assign count_inc  = count_reg + COUNT_W'(1);
    assign calibrated = (state_reg == ST_RUN);

    // Next state and lane commands
    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        div_cnt_next       = div_cnt_reg;
        lane_ctrl          = '0;
        lane_ctrl.clear    = restart;
        lane_ctrl.s1_load  = accept;
        lane_ctrl.s1_zero  = restart || (state_reg != ST_RUN);

        unique case (state_reg)
            ST_CAL:
            begin
                if (restart)
                begin
                    count_next = '0;
                end
                else if (accept)
                begin
                    lane_ctrl.accum = 1'b1;
                    count_next      = count_inc;
                    if (count_inc >= CAL_COUNT)
                    begin
                        state_next   = ST_DIV;
                        div_cnt_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                div_cnt_next       = div_cnt_reg + DIV_CNT_W'(1);
                lane_ctrl.div_load = (div_cnt_reg == '0);
                lane_ctrl.div_step = (div_cnt_reg != '0)
                                  && (div_cnt_reg != DIV_CNT_W'(DIV_LAST));
                if (div_cnt_reg == DIV_CNT_W'(DIV_LAST))
                begin
                    lane_ctrl.div_done = 1'b1;
                    state_next         = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (restart)
                begin
                    state_next = ST_CAL;
                    count_next = '0;
                end
            end
            default:
            begin
                state_next = ST_CAL;
            end
        endcase
    end

    // Assertions
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CAL_COUNT)
    `ASSERT_IMPLIES(a_no_accept_div, clk, rst_n, state_reg == ST_DIV, !in_ready)
    `ASSERT_IMPLIES(a_run_count, clk, rst_n, state_reg == ST_RUN, count_reg == CAL_COUNT)
    `ASSERT_NEXT(a_done_runs, clk, rst_n, lane_ctrl.div_done, state_reg == ST_RUN)

endmodule

/* rtl/ibcs_gyro_lane.sv */
// ---------------------------------------------------------------------------
// ibcs_gyro_lane
// One gyro axis: calibration sum, reciprocal bias divider, bias subtraction
// with saturation, stage-1 register and the rad/s scaling multiplier.
// ---------------------------------------------------------------------------
module ibcs_gyro_lane
    import ibcs_pkg::*;
#(
    parameter int CAL_SAMPLES = 300
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctrl_t               ctrl,
    input  logic signed [RAW_W-1:0]  gyro_raw,
    output logic signed [RADS_W-1:0] rads
);

    // |sum| < 2^MAG_W, so floor(|sum| * RECIP / 2^DIV_SH) is the exact quotient
    localparam int                          DIV_L     = $clog2(CAL_SAMPLES);
    localparam int                          DIV_SH    = MAG_W + DIV_L;
    localparam int                          DIV_P_W   = MAG_W + DIV_SH + 1;
    localparam longint                      RECIP_VAL =
        ((longint'(1) << DIV_SH) + longint'(CAL_SAMPLES) - longint'(1))
        / longint'(CAL_SAMPLES);
    localparam logic [MAG_W:0]              RECIP     = (MAG_W + 1)'(RECIP_VAL);
    localparam logic signed [SUM_W-1:0]     Q_HI      = SUM_W'(RAW_MAX);
    localparam logic signed [SUM_W-1:0]     Q_LO      = SUM_W'(RAW_MIN);
    localparam logic signed [RAW_W:0]       D_HI      = (RAW_W + 1)'(RAW_MAX);
    localparam logic signed [RAW_W:0]       D_LO      = (RAW_W + 1)'(RAW_MIN);

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [RAW_W-1:0]  bias_reg, bias_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [MAG_W-1:0]         quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic signed [RAW_W-1:0]  corr_reg, corr_next;

    logic signed [SUM_W-1:0]  gyro_ext;
    logic signed [SUM_W-1:0]  sum_abs;
    logic [MAG_W-1:0]         sum_mag;
    logic [DIV_P_W-1:0]       div_prod;
    logic signed [SUM_W-1:0]  quo_ext;
    logic signed [SUM_W-1:0]  quo_signed;
    logic signed [RAW_W-1:0]  bias_sat;
    logic signed [RAW_W:0]    diff;
    logic signed [RAW_W-1:0]  corr_sat;
    logic signed [PROD_W-1:0] prod;

    // Calibration sum and bias hold architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            bias_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            bias_reg <= bias_next;
        end
    end

    // Divider and stage-1 datapath
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        corr_reg <= corr_next;
    end

    // Sum update
    assign gyro_ext = {{(SUM_W - RAW_W){gyro_raw[RAW_W-1]}}, gyro_raw};

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.accum)
        begin
            sum_next = sum_reg + gyro_ext;
        end
    end

    // Divide |sum| by the sample count: register the magnitude, then multiply
    // by the rounded-up reciprocal and keep the bits above the shift
    assign sum_abs  = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
    assign sum_mag  = sum_abs[MAG_W-1:0];
    assign div_prod = DIV_P_W'(mag_reg) * DIV_P_W'(RECIP);

    always_comb
    begin
        mag_next = mag_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        if (ctrl.div_load)
        begin
            mag_next = sum_mag;
            neg_next = sum_reg[SUM_W-1];
        end
        else if (ctrl.div_step)
        begin
            quo_next = div_prod[DIV_SH +: MAG_W];
        end
    end

    // Signed quotient, truncated toward zero, saturated to a raw reading
    assign quo_ext    = {1'b0, quo_reg};
    assign quo_signed = neg_reg ? (~quo_ext + SUM_W'(1)) : quo_ext;

    always_comb
    begin
        priority if (quo_signed > Q_HI)
            bias_sat = RAW_W'(RAW_MAX);
        else if (quo_signed < Q_LO)
            bias_sat = RAW_W'(RAW_MIN);
        else
            bias_sat = quo_signed[RAW_W-1:0];
    end

    always_comb
    begin
        bias_next = bias_reg;
        if (ctrl.clear)
        begin
            bias_next = '0;
        end
        else if (ctrl.div_done)
        begin
            bias_next = bias_sat;
        end
    end

    // Bias subtraction with saturation
    assign diff = {gyro_raw[RAW_W-1], gyro_raw} - {bias_reg[RAW_W-1], bias_reg};

    always_comb
    begin
        priority if (diff > D_HI)
            corr_sat = RAW_W'(RAW_MAX);
        else if (diff < D_LO)
            corr_sat = RAW_W'(RAW_MIN);
        else
            corr_sat = diff[RAW_W-1:0];
    end

    always_comb
    begin
        corr_next = corr_reg;
        if (ctrl.s1_load)
        begin
            corr_next = ctrl.s1_zero ? '0 : corr_sat;
        end
    end

    // Scale to rad/s; dropping the low bits is a floor shift
    assign prod = corr_reg * GYRO_SCALE;
    assign rads = prod[FRAC_W+RADS_W-1:FRAC_W];

endmodule

/* rtl/ibcs_out_merge.sv */
// ---------------------------------------------------------------------------
// ibcs_out_merge
// Output stage: joins the three lane results with the accel pass-through and
// the status bit into one registered result transaction.
// ---------------------------------------------------------------------------
module ibcs_out_merge
    import ibcs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     ready_in,
    input  logic signed [RAW_W-1:0]  accel_in [NUM_AXES],
    input  logic signed [RADS_W-1:0] gyro_in [NUM_AXES],
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     ready_out,
    output logic signed [RAW_W-1:0]  accel_out [NUM_AXES],
    output logic signed [RADS_W-1:0] gyro_out [NUM_AXES]
);

    logic                     valid_reg, valid_next;
    logic                     ready_res_reg;
    logic signed [RAW_W-1:0]  accel_reg [NUM_AXES];
    logic signed [RADS_W-1:0] gyro_reg [NUM_AXES];
    logic                     load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ready_res_reg <= ready_in;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                accel_reg[i] <= accel_in[i];
                gyro_reg[i]  <= gyro_in[i];
            end
        end
    end

    assign out_valid = valid_reg;
    assign ready_out = ready_res_reg;
    assign accel_out = accel_reg;
    assign gyro_out  = gyro_reg;

endmodule

/* rtl/imu_bias_calibrate_and_scale.sv */
// ---------------------------------------------------------------------------
// imu_bias_calibrate_and_scale
// Gyro zero-bias calibration and unit scaling for one IMU sample per transaction.
// ---------------------------------------------------------------------------
// Accepts one sample per clock unless held off by out_ready or the bias divide,
// and returns one result per sample through the stage-1 register, then the
// output register; the output register lets a new sample enter while a result
// waits on out_ready. After reset or a restart sample, the first CAL_SAMPLES
// samples are summed per axis and reported with ready_res low and zero gyro
// fields. The sample that completes calibration starts a per-axis divide by
// CAL_SAMPLES done as a multiply by a constant reciprocal, so in_ready stays low
// through the magnitude load, multiply and bias write, once per calibration. A
// restart sample returns an all-zero result. Gyro outputs are rad/s with 16
// fractional bits, accel outputs are the raw readings as g in Q3.12.
// ---------------------------------------------------------------------------
module imu_bias_calibrate_and_scale
    import ibcs_pkg::*;
#(
    parameter int CAL_SAMPLES = 300
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [RAW_W-1:0]  accel_x_raw,
    input  logic signed [RAW_W-1:0]  accel_y_raw,
    input  logic signed [RAW_W-1:0]  accel_z_raw,
    input  logic signed [RAW_W-1:0]  gyro_x_raw,
    input  logic signed [RAW_W-1:0]  gyro_y_raw,
    input  logic signed [RAW_W-1:0]  gyro_z_raw,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     ready_res,
    output logic signed [RAW_W-1:0]  accel_x_g,
    output logic signed [RAW_W-1:0]  accel_y_g,
    output logic signed [RAW_W-1:0]  accel_z_g,
    output logic signed [RADS_W-1:0] gyro_x_rads,
    output logic signed [RADS_W-1:0] gyro_y_rads,
    output logic signed [RADS_W-1:0] gyro_z_rads
);

    lane_ctrl_t               lane_ctrl;
    logic                     calibrated;
    logic                     s1_ready;
    logic                     merge_ready;
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_res_reg;
    logic signed [RAW_W-1:0]  s1_accel_reg [NUM_AXES];
    logic signed [RAW_W-1:0]  accel_raw [NUM_AXES];
    logic signed [RAW_W-1:0]  gyro_raw [NUM_AXES];
    logic signed [RADS_W-1:0] lane_rads [NUM_AXES];
    logic signed [RAW_W-1:0]  accel_g [NUM_AXES];
    logic signed [RADS_W-1:0] gyro_rads [NUM_AXES];
    logic                     is_restart;

    assign accel_raw[0] = accel_x_raw;
    assign accel_raw[1] = accel_y_raw;
    assign accel_raw[2] = accel_z_raw;
    assign gyro_raw[0]  = gyro_x_raw;
    assign gyro_raw[1]  = gyro_y_raw;
    assign gyro_raw[2]  = gyro_z_raw;

    // Calibration sequencer
    ibcs_cal_ctrl #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .action     (action),
        .s1_ready   (s1_ready),
        .in_ready   (in_ready),
        .calibrated (calibrated),
        .lane_ctrl  (lane_ctrl)
    );

    // One lane per gyro axis
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        ibcs_gyro_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .gyro_raw (gyro_raw[g]),
            .rads     (lane_rads[g])
        );
    end

    // Stage 1: status and accel side band alongside the lane corr registers
    assign is_restart = (action == ACT_RESTART);
    assign s1_ready   = !s1_valid_reg || merge_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (lane_ctrl.s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (merge_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctrl.s1_load)
        begin
            s1_res_reg <= calibrated && !is_restart;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s1_accel_reg[i] <= is_restart ? '0 : accel_raw[i];
            end
        end
    end

    // Output register
    ibcs_out_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (merge_ready),
        .ready_in  (s1_res_reg),
        .accel_in  (s1_accel_reg),
        .gyro_in   (lane_rads),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ready_out (ready_res),
        .accel_out (accel_g),
        .gyro_out  (gyro_rads)
    );

    assign accel_x_g   = accel_g[0];
    assign accel_y_g   = accel_g[1];
    assign accel_z_g   = accel_g[2];
    assign gyro_x_rads = gyro_rads[0];
    assign gyro_y_rads = gyro_rads[1];
    assign gyro_z_rads = gyro_rads[2];

endmodule
